// ----- rtl/dst_window_check_top_assert.svh -----
// ----------------------------------------------------------------------------
// dst window check assertion macros
// property forms for the checker file, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef DST_WINDOW_CHECK_TOP_ASSERT_SVH
`define DST_WINDOW_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define DWC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define DWC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- rtl/dwc_pkg.sv -----
// ----------------------------------------------------------------------------
// dwc_pkg
// widths, register codes and calendar tables of the dst window check
// ----------------------------------------------------------------------------
package dwc_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int WD_W = 3;
	localparam int INST_W = 3;

	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1970;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	// occurrence code for the last weekday of the month
	localparam logic [INST_W-1:0] INST_LAST = 3'd4;

	// x / 100 as (x * 5243) >> 19, exact below 43690
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	// x / 7 as (x * 37450) >> 18, exact below 43690
	localparam logic [15:0] DIV7_MUL = 16'd37450;
	localparam int DIV7_SHIFT = 18;

	typedef enum logic [2:0] {
		REG_DST_ENABLE     = 3'd0,
		REG_START_MONTH    = 3'd1,
		REG_START_WEEKDAY  = 3'd2,
		REG_START_INSTANCE = 3'd3,
		REG_END_MONTH      = 3'd4,
		REG_END_WEEKDAY    = 3'd5,
		REG_END_INSTANCE   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [WD_W-1:0]    weekday;
		logic [INST_W-1:0]  instance_sel;
	} rule_t;

	// weekday offset of each month for the day-of-week sum
	function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [2:0] o;
		case (m)
			4'd1:    o = 3'd0;
			4'd2:    o = 3'd3;
			4'd3:    o = 3'd2;
			4'd4:    o = 3'd5;
			4'd5:    o = 3'd0;
			4'd6:    o = 3'd3;
			4'd7:    o = 3'd5;
			4'd8:    o = 3'd1;
			4'd9:    o = 3'd4;
			4'd10:   o = 3'd6;
			4'd11:   o = 3'd2;
			4'd12:   o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] l;
		case (m) inside
			4'd2:                     l = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  l = 5'd30;
			default:                  l = 5'd31;
		endcase
		return l;
	endfunction

endpackage

// ----- rtl/dst_window_check_top.sv -----
// ----------------------------------------------------------------------------
// dst_window_check_top
// daylight-saving window test: one date word in, boundary days and flag out
// six register stages between input accept and output valid
// throughput: one word per cycle while the output is not stalled; each stage holds on its own when stalled
// the two multiply stages (div by 100, div by 7) set the stage count
// reset: arst_n clears the valid bits and loads the rule registers' defaults
// ----------------------------------------------------------------------------
module dst_window_check_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// input word
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// date_year [13:0], date_month [17:14], date_day [22:18], zero [23]
	input  logic [dwc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// output word
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// dst_active [0], start_day_of_month [5:1], end_day_of_month [10:6],
	// zero [15:11]
	output logic [dwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dwc_pkg::PADDR_W-1:0]     paddr,
	input  logic [dwc_pkg::PDATA_W-1:0]     pwdata,
	output logic [dwc_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	// ------------------------------------------------------------------
	// rule registers
	// ------------------------------------------------------------------
	logic                         dst_enable_q;
	logic [dwc_pkg::MONTH_W-1:0]  start_month_q;
	logic [dwc_pkg::WD_W-1:0]     start_weekday_q;
	logic [dwc_pkg::INST_W-1:0]   start_instance_q;
	logic [dwc_pkg::MONTH_W-1:0]  end_month_q;
	logic [dwc_pkg::WD_W-1:0]     end_weekday_q;
	logic [dwc_pkg::INST_W-1:0]   end_instance_q;

	logic             cfg_wr;
	dwc_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = dwc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_enable_q     <= 1'b0;
			start_month_q    <= 4'd3;
			start_weekday_q  <= 3'd0;
			start_instance_q <= 3'd1;
			end_month_q      <= 4'd11;
			end_weekday_q    <= 3'd0;
			end_instance_q   <= 3'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				dwc_pkg::REG_DST_ENABLE:     dst_enable_q     <= pwdata[0];
				dwc_pkg::REG_START_MONTH:    start_month_q    <= pwdata[3:0];
				dwc_pkg::REG_START_WEEKDAY:  start_weekday_q  <= pwdata[2:0];
				dwc_pkg::REG_START_INSTANCE: start_instance_q <= pwdata[2:0];
				dwc_pkg::REG_END_MONTH:      end_month_q      <= pwdata[3:0];
				dwc_pkg::REG_END_WEEKDAY:    end_weekday_q    <= pwdata[2:0];
				dwc_pkg::REG_END_INSTANCE:   end_instance_q   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			dwc_pkg::REG_DST_ENABLE:     prdata[0]   = dst_enable_q;
			dwc_pkg::REG_START_MONTH:    prdata[3:0] = start_month_q;
			dwc_pkg::REG_START_WEEKDAY:  prdata[2:0] = start_weekday_q;
			dwc_pkg::REG_START_INSTANCE: prdata[2:0] = start_instance_q;
			dwc_pkg::REG_END_MONTH:      prdata[3:0] = end_month_q;
			dwc_pkg::REG_END_WEEKDAY:    prdata[2:0] = end_weekday_q;
			dwc_pkg::REG_END_INSTANCE:   prdata[2:0] = end_instance_q;
			default:                     prdata      = '0;
		endcase
	end

	// rule 0 is the start rule, rule 1 the end rule
	dwc_pkg::rule_t rule [2];
	logic           rule_ok [2];

	assign rule[0] = '{month: start_month_q, weekday: start_weekday_q,
		instance_sel: start_instance_q};
	assign rule[1] = '{month: end_month_q, weekday: end_weekday_q,
		instance_sel: end_instance_q};

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			rule_ok[r] = (rule[r].month >= 4'd1) && (rule[r].month <= 4'd12) &&
				(rule[r].weekday <= 3'd6) && (rule[r].instance_sel <= dwc_pkg::INST_LAST);
		end
	end

	// ------------------------------------------------------------------
	// stage handshake: a stage takes a new word when it is empty or when
	// the stage after it moves, so bubbles close up under a stall
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || m_axis_tready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: unpack and clamp the year to 1970..9999
	// ------------------------------------------------------------------
	logic [dwc_pkg::YEAR_W-1:0]  in_year;
	logic [dwc_pkg::YEAR_W-1:0]  sat_year;
	logic [dwc_pkg::YEAR_W-1:0]  year_s1;
	logic [dwc_pkg::MONTH_W-1:0] dm_s1;
	logic [dwc_pkg::DAY_W-1:0]   dd_s1;

	assign in_year  = s_axis_tdata[13:0];
	assign sat_year = (in_year < dwc_pkg::YEAR_MIN) ? dwc_pkg::YEAR_MIN :
		(in_year > dwc_pkg::YEAR_MAX) ? dwc_pkg::YEAR_MAX : in_year;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			year_s1 <= sat_year;
			dm_s1   <= s_axis_tdata[17:14];
			dd_s1   <= s_axis_tdata[22:18];
		end
	end

	// ------------------------------------------------------------------
	// stage 2: century terms by reciprocal multiply
	// each rule uses the previous year for january and february
	// ------------------------------------------------------------------
	logic [13:0] ry      [2];
	logic [26:0] p100    [2];
	logic [24:0] p400    [2];
	logic [26:0] yp100;
	logic [24:0] yp400;

	logic [13:0] ry_s2   [2];
	logic [11:0] q4_s2   [2];
	logic [6:0]  q100_s2 [2];
	logic [4:0]  q400_s2 [2];
	logic [13:0] year_s2;
	logic [6:0]  yq100_s2;
	logic [4:0]  yq400_s2;
	logic [dwc_pkg::MONTH_W-1:0] dm_s2;
	logic [dwc_pkg::DAY_W-1:0]   dd_s2;

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			ry[r]   = year_s1 - {13'd0, (rule[r].month < 4'd3)};
			p100[r] = 27'(ry[r]) * 27'(dwc_pkg::DIV100_MUL);
			p400[r] = 25'(ry[r][13:2]) * 25'(dwc_pkg::DIV100_MUL);
		end
	end

	assign yp100 = 27'(year_s1) * 27'(dwc_pkg::DIV100_MUL);
	assign yp400 = 25'(year_s1[13:2]) * 25'(dwc_pkg::DIV100_MUL);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int r = 0; r < 2; r++) begin
				ry_s2[r]   <= ry[r];
				q4_s2[r]   <= ry[r][13:2];
				q100_s2[r] <= p100[r][dwc_pkg::DIV100_SHIFT +: 7];
				q400_s2[r] <= p400[r][dwc_pkg::DIV100_SHIFT +: 5];
			end
			year_s2  <= year_s1;
			yq100_s2 <= yp100[dwc_pkg::DIV100_SHIFT +: 7];
			yq400_s2 <= yp400[dwc_pkg::DIV100_SHIFT +: 5];
			dm_s2    <= dm_s1;
			dd_s2    <= dd_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: leap year, month length and the day-of-week sum
	// ------------------------------------------------------------------
	logic        leap;
	logic [4:0]  len    [2];
	logic [4:0]  dsel   [2];
	logic [14:0] wsum   [2];

	logic [14:0] sum_s3 [2];
	logic [4:0]  len_s3 [2];
	logic [dwc_pkg::MONTH_W-1:0] dm_s3;
	logic [dwc_pkg::DAY_W-1:0]   dd_s3;

	assign leap = (year_s2[1:0] == 2'd0) &&
		((year_s2 != 14'({7'd0, yq100_s2} * 14'd100)) ||
		 (year_s2[13:2] == 12'({7'd0, yq400_s2} * 12'd100)));

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			len[r]  = dwc_pkg::month_len(rule[r].month, leap);
			// last-weekday rules look at the month's last day, others at its first
			dsel[r] = (rule[r].instance_sel == dwc_pkg::INST_LAST) ? len[r] : 5'd1;
			wsum[r] = 15'(ry_s2[r]) + 15'(q4_s2[r]) - 15'(q100_s2[r]) +
				15'(q400_s2[r]) + 15'(dwc_pkg::month_offset(rule[r].month)) +
				15'(dsel[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int r = 0; r < 2; r++) begin
				sum_s3[r] <= wsum[r];
				len_s3[r] <= len[r];
			end
			dm_s3 <= dm_s2;
			dd_s3 <= dd_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: quotient of the sum by 7
	// ------------------------------------------------------------------
	logic [30:0] p7     [2];
	logic [10:0] q7_s4  [2];
	logic [14:0] sum_s4 [2];
	logic [4:0]  len_s4 [2];
	logic [dwc_pkg::MONTH_W-1:0] dm_s4;
	logic [dwc_pkg::DAY_W-1:0]   dd_s4;

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			p7[r] = 31'(sum_s3[r]) * 31'(dwc_pkg::DIV7_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int r = 0; r < 2; r++) begin
				q7_s4[r]  <= p7[r][dwc_pkg::DIV7_SHIFT +: 11];
				sum_s4[r] <= sum_s3[r];
				len_s4[r] <= len_s3[r];
			end
			dm_s4 <= dm_s3;
			dd_s4 <= dd_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: weekday and the boundary day of each rule
	// ------------------------------------------------------------------
	logic [14:0] rem    [2];
	logic [2:0]  dow    [2];
	logic [3:0]  dl     [2];
	logic [3:0]  df     [2];
	logic [2:0]  ml     [2];
	logic [2:0]  mf     [2];
	logic [4:0]  bday   [2];

	logic [4:0]  day_s5 [2];
	logic [dwc_pkg::MONTH_W-1:0] dm_s5;
	logic [dwc_pkg::DAY_W-1:0]   dd_s5;

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			rem[r] = sum_s4[r] - 15'({4'd0, q7_s4[r]} * 15'd7);
			dow[r] = rem[r][2:0];
			// back from the last day to the wanted weekday
			dl[r]  = {1'b0, dow[r]} + 4'd7 - {1'b0, rule[r].weekday};
			ml[r]  = (dl[r] >= 4'd7) ? 3'(dl[r] - 4'd7) : dl[r][2:0];
			// forward from the first day to the wanted weekday
			df[r]  = {1'b0, rule[r].weekday} + 4'd7 - {1'b0, dow[r]};
			mf[r]  = (df[r] >= 4'd7) ? 3'(df[r] - 4'd7) : df[r][2:0];
			if (rule[r].instance_sel == dwc_pkg::INST_LAST) begin
				bday[r] = len_s4[r] - {2'd0, ml[r]};
			end else begin
				bday[r] = 5'd1 + {2'd0, mf[r]} +
					({rule[r].instance_sel[1:0], 3'd0} - {3'd0, rule[r].instance_sel[1:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			for (int r = 0; r < 2; r++) begin
				day_s5[r] <= bday[r];
			end
			dm_s5 <= dm_s4;
			dd_s5 <= dd_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: window compare on month*31 + day keys, output register
	// an invalid rule zeroes both boundary days and the flag
	// ------------------------------------------------------------------
	logic       both_ok;
	logic [8:0] key;
	logic [8:0] skey;
	logic [8:0] ekey;
	logic       in_window;
	logic       active_s6;
	logic [4:0] sday_s6;
	logic [4:0] eday_s6;

	assign both_ok = rule_ok[0] && rule_ok[1];
	assign key  = {dm_s5, 5'd0} - {5'd0, dm_s5} + {4'd0, dd_s5};
	assign skey = {rule[0].month, 5'd0} - {5'd0, rule[0].month} + {4'd0, day_s5[0]};
	assign ekey = {rule[1].month, 5'd0} - {5'd0, rule[1].month} + {4'd0, day_s5[1]};
	assign in_window = (key >= skey) && (key < ekey);

	always_ff @(posedge clk) begin
		if (rdy6) begin
			active_s6 <= both_ok && dst_enable_q && in_window;
			sday_s6   <= both_ok ? day_s5[0] : 5'd0;
			eday_s6   <= both_ok ? day_s5[1] : 5'd0;
		end
	end

	assign m_axis_tdata = {5'd0, eday_s6, sday_s6, active_s6};

endmodule

// ----- rtl/dwc_checker.sv -----
// ----------------------------------------------------------------------------
// dwc_checker
// port-level checks of the dst window check, bound to the top level
// ----------------------------------------------------------------------------
`include "dst_window_check_top_assert.svh"

module dwc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled output word holds
	`DWC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// input side only backs up behind a stalled output
	`DWC_ASSERT_IMP(a_in_ready, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// start and end days are zeroed together
	`DWC_ASSERT_IMP(a_days_pair, m_axis_tvalid, (m_axis_tdata[5:1] == 5'd0) == (m_axis_tdata[10:6] == 5'd0))

	// an active date needs a real start day
	`DWC_ASSERT_IMP(a_active_day, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[5:1] != 5'd0)

endmodule

bind dst_window_check_top dwc_checker u_dwc_checker (.*);

// ----- tb/sv/tb_dst_window_check_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dst_window_check_top
// drives calendar date words into the dst window check and compares every
// result word with a built-in calculation of both rule boundary days and the
// window flag; rules are rewritten over the register port between test phases
// ----------------------------------------------------------------------------
module tb_dst_window_check_top;
	import dwc_pkg::*;

	localparam int CLK_HIGH = 6;
	localparam int CLK_LOW = 6;
	localparam int RESET_CYCLES = 7;
	// pipeline is six stages deep; PIPE_TAIL pads the drain wait before registers are touched
	localparam int PIPE_TAIL = 12;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int DATES_PER_PHASE = 250;
	localparam int PRESSURE_DATES = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_GAP = 5;
	localparam int MONTH_KEY = 31;

	// field order matches the output word: dst_active in the lowest bit
	typedef struct packed {
		logic [DAY_W-1:0] end_dom;
		logic [DAY_W-1:0] start_dom;
		logic             active;
	} window_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// date_year [13:0], date_month [17:14], date_day [22:18], zero [23]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// dst_active [0], start_day_of_month [5:1], end_day_of_month [10:6],
	// zero [15:11]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]     pwdata = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	// shadow copy of the rule registers, updated at the write edge
	logic  saving_on;
	rule_t start_rule;
	rule_t end_rule;

	// one entry per accepted date word, oldest first
	window_t pending_windows[$];

	// neither side inserts random idle cycles while this is set
	bit steady_flow = 1'b0;
	// a nonzero value asks the sink for one long hold-off of that many cycles
	int sink_hold = 0;

	int mismatches = 0;
	int dates_sent = 0;
	int results_checked = 0;
	int rule_sets = 0;
	int cycle_count = 0;

	dst_window_check_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#CLK_LOW clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// calendar arithmetic for the expected result
	// ------------------------------------------------------------------

	function automatic int unsigned clamp_year(input int unsigned y);
		if (y < YEAR_MIN)
			return YEAR_MIN;
		if (y > YEAR_MAX)
			return YEAR_MAX;
		return y;
	endfunction

	// zeller's congruence, remapped so that sunday is 0
	function automatic int unsigned weekday_of(input int unsigned y, input int unsigned m,
		input int unsigned d);
		int unsigned k, j, h;
		if (m < 3) begin
			m += 12;
			y -= 1;
		end
		k = y % 100;
		j = y / 100;
		h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
		// zeller counts from saturday
		return (h + 6) % 7;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			2: begin
				if ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)
					return 29;
				return 28;
			end
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// day of month picked out by one rule, 0 when the rule codes are unusable
	function automatic int unsigned boundary_day(input int unsigned y, input int unsigned m,
		input int unsigned wd, input int unsigned inst);
		int unsigned len, first;
		if (m < 1 || m > 12 || wd > 6 || inst > INST_LAST)
			return 0;
		len = days_in_month(y, m);
		if (inst == INST_LAST)
			return len - ((weekday_of(y, m, len) + 7 - wd) % 7);
		first = 1 + ((wd + 7 - weekday_of(y, m, 1)) % 7);
		return first + 7 * inst;
	endfunction

	function automatic window_t predict_window(input logic [YEAR_W-1:0] year,
		input logic [MONTH_W-1:0] month, input logic [DAY_W-1:0] day);
		window_t w;
		int unsigned y, sd, ed, key, start_key, end_key;
		w = '0;
		y = clamp_year(year);
		sd = boundary_day(y, start_rule.month, start_rule.weekday, start_rule.instance_sel);
		ed = boundary_day(y, end_rule.month, end_rule.weekday, end_rule.instance_sel);
		// one unusable rule blanks both days and the flag
		if (sd != 0 && ed != 0) begin
			w.start_dom = sd[DAY_W-1:0];
			w.end_dom = ed[DAY_W-1:0];
			key = int'(month) * MONTH_KEY + int'(day);
			start_key = int'(start_rule.month) * MONTH_KEY + sd;
			end_key = int'(end_rule.month) * MONTH_KEY + ed;
			w.active = saving_on && key >= start_key && key < end_key;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// the register takes the value at this edge, so does the shadow
		case (idx)
			REG_DST_ENABLE:     saving_on = value[0];
			REG_START_MONTH:    start_rule.month = value[MONTH_W-1:0];
			REG_START_WEEKDAY:  start_rule.weekday = value[WD_W-1:0];
			REG_START_INSTANCE: start_rule.instance_sel = value[INST_W-1:0];
			REG_END_MONTH:      end_rule.month = value[MONTH_W-1:0];
			REG_END_WEEKDAY:    end_rule.weekday = value[WD_W-1:0];
			REG_END_INSTANCE:   end_rule.instance_sel = value[INST_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// read one register back and compare it with the shadow
	task automatic check_register(input reg_idx_t idx);
		logic [PDATA_W-1:0] want;
		case (idx)
			REG_DST_ENABLE:     want = PDATA_W'(saving_on);
			REG_START_MONTH:    want = PDATA_W'(start_rule.month);
			REG_START_WEEKDAY:  want = PDATA_W'(start_rule.weekday);
			REG_START_INSTANCE: want = PDATA_W'(start_rule.instance_sel);
			REG_END_MONTH:      want = PDATA_W'(end_rule.month);
			REG_END_WEEKDAY:    want = PDATA_W'(end_rule.weekday);
			REG_END_INSTANCE:   want = PDATA_W'(end_rule.instance_sel);
			default:            want = '0;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$error("register %s: expected %0h, actual %0h", idx.name(), want, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// stream side
	// ------------------------------------------------------------------

	// drop valid and wait until every outstanding result word is back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_windows.size() != 0) @(negedge clk);
		repeat (PIPE_TAIL) @(negedge clk);
	endtask

	task automatic set_rules(input logic en, input logic [MONTH_W-1:0] sm,
		input logic [WD_W-1:0] swd, input logic [INST_W-1:0] sinst,
		input logic [MONTH_W-1:0] em, input logic [WD_W-1:0] ewd,
		input logic [INST_W-1:0] einst);
		wait_idle();
		apb_write(REG_DST_ENABLE, PDATA_W'(en));
		apb_write(REG_START_MONTH, PDATA_W'(sm));
		apb_write(REG_START_WEEKDAY, PDATA_W'(swd));
		apb_write(REG_START_INSTANCE, PDATA_W'(sinst));
		apb_write(REG_END_MONTH, PDATA_W'(em));
		apb_write(REG_END_WEEKDAY, PDATA_W'(ewd));
		apb_write(REG_END_INSTANCE, PDATA_W'(einst));
		for (int i = 0; i <= int'(REG_END_INSTANCE); i++)
			check_register(reg_idx_t'(i));
		rule_sets++;
	endtask

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_date(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month,
		input logic [DAY_W-1:0] day);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {1'b0, day, month, year};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		// accepted at this edge, the rules cannot change while words are in flight
		pending_windows.push_back(predict_window(year, month, day));
		dates_sent++;
		@(negedge clk);
	endtask

	// result sink: random stall before each word, plus an optional long hold-off
	initial begin : result_sink
		int stall;
		int hold_len;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (sink_hold > 0) begin
				hold_len = sink_hold;
				sink_hold = 0;
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
			end
			stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// every accepted result word against the oldest expectation
	always @(posedge clk) begin : result_check
		window_t got;
		window_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = window_t'(m_axis_tdata[2*DAY_W:0]);
			if (pending_windows.size() == 0) begin
				$error("result word %0h with no date outstanding", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_windows.pop_front();
				if (got.active !== want.active) begin
					$error("dst_active: expected %0d, actual %0d", want.active, got.active);
					mismatches++;
				end
				if (got.start_dom !== want.start_dom) begin
					$error("start_day_of_month: expected %0d, actual %0d",
						want.start_dom, got.start_dom);
					mismatches++;
				end
				if (got.end_dom !== want.end_dom) begin
					$error("end_day_of_month: expected %0d, actual %0d",
						want.end_dom, got.end_dom);
					mismatches++;
				end
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
				pending_windows.size());
			$display("tb_dst_window_check_top failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// register defaults after reset; saving is off but both days are reported
	task automatic test_reset_state();
		for (int i = 0; i <= int'(REG_END_INSTANCE); i++)
			check_register(reg_idx_t'(i));
		send_date(14'd2024, 4'd7, 5'd4);
	endtask

	task automatic test_directed_dates();
		int unsigned sd, ed;
		// second sunday of march to first sunday of november
		set_rules(1'b1, 4'd3, 3'd0, 3'd1, 4'd11, 3'd0, 3'd0);
		sd = boundary_day(2024, 3, 0, 1);
		ed = boundary_day(2024, 11, 0, 0);
		// start day is inside, the day before is not; end day is already outside
		send_date(14'd2024, 4'd3, 5'(sd));
		send_date(14'd2024, 4'd3, 5'(sd - 1));
		send_date(14'd2024, 4'd11, 5'(ed - 1));
		send_date(14'd2024, 4'd11, 5'(ed));
		// years below, on and above the clamp bounds, all year bits set
		send_date(14'd0, 4'd6, 5'd15);
		send_date(14'd1970, 4'd7, 5'd4);
		send_date(14'd9999, 4'd7, 5'd4);
		send_date(14'd10000, 4'd7, 5'd4);
		send_date(14'h3FFF, 4'd8, 5'd31);
		// month and day outside the calendar go into the key as they are
		send_date(14'd2030, 4'd0, 5'd0);
		send_date(14'd2030, 4'd15, 5'd31);
	endtask

	task automatic test_rule_extremes();
		// widest window: first sunday of january to last saturday of december
		set_rules(1'b1, 4'd1, 3'd0, 3'd0, 4'd12, 3'd6, INST_LAST);
		send_date(14'd1970, 4'd1, 5'd1);
		send_date(14'd9999, 4'd12, 5'd31);
		// last monday of february shifts with the leap day
		set_rules(1'b1, 4'd2, 3'd1, INST_LAST, 4'd12, 3'd6, 3'd3);
		send_date(14'd2000, 4'd2, 5'd29);
		send_date(14'd2100, 4'd2, 5'd28);
		send_date(14'd2024, 4'd2, 5'd26);
		send_date(14'd2023, 4'd3, 5'd1);
		// start after end leaves an empty window
		set_rules(1'b1, 4'd10, 3'd0, INST_LAST, 4'd3, 3'd0, 3'd1);
		send_date(14'd2025, 4'd12, 5'd1);
		// both boundaries in the same month
		set_rules(1'b1, 4'd6, 3'd2, 3'd0, 4'd6, 3'd2, 3'd3);
		send_date(14'd2025, 4'd6, 5'd14);
	endtask

	// each unusable rule code blanks both days and the flag
	task automatic test_invalid_rules();
		set_rules(1'b1, 4'd0, 3'd0, 3'd1, 4'd11, 3'd0, 3'd0);
		send_date(14'd2024, 4'd6, 5'd1);
		set_rules(1'b1, 4'd3, 3'd0, 3'd1, 4'd15, 3'd0, 3'd0);
		send_date(14'd2024, 4'd6, 5'd1);
		set_rules(1'b1, 4'd3, 3'd7, 3'd1, 4'd11, 3'd0, 3'd0);
		send_date(14'd2024, 4'd6, 5'd1);
		set_rules(1'b1, 4'd3, 3'd0, 3'd1, 4'd11, 3'd0, 3'd5);
		send_date(14'd2024, 4'd6, 5'd1);
	endtask

	// valid rules, date inside the window, saving switched off
	task automatic test_disabled();
		set_rules(1'b0, 4'd3, 3'd0, INST_LAST, 4'd10, 3'd0, INST_LAST);
		send_date(14'd2024, 4'd7, 5'd1);
	endtask

	task automatic test_random_dates();
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		rule_t              near_rule;
		int unsigned        bd;
		int                 pick;
		int                 dd;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if ($urandom_range(0, 7) == 0) begin
				// any code the register fields can hold, unusable ones included
				set_rules(1'($urandom_range(0, 1)), 4'($urandom), 3'($urandom), 3'($urandom),
					4'($urandom), 3'($urandom), 3'($urandom));
			end else begin
				set_rules($urandom_range(0, 4) != 0, 4'($urandom_range(1, 12)),
					3'($urandom_range(0, 6)), 3'($urandom_range(0, 4)),
					4'($urandom_range(1, 12)), 3'($urandom_range(0, 6)),
					3'($urandom_range(0, 4)));
			end
			steady_flow = (phase % 3 == 2);
			for (int i = 0; i < DATES_PER_PHASE; i++) begin
				pick = $urandom_range(0, 9);
				year = 14'($urandom_range(1970, 9999));
				month = 4'($urandom_range(1, 12));
				day = 5'($urandom_range(1, 31));
				if (pick < 2) begin
					// raw field values, clamped years and off-calendar dates
					year = 14'($urandom);
					month = 4'($urandom);
					day = 5'($urandom);
				end else if (pick < 6) begin
					// land on or right beside one of the two boundary days
					near_rule = $urandom_range(0, 1) ? start_rule : end_rule;
					bd = boundary_day(clamp_year(year), near_rule.month, near_rule.weekday,
						near_rule.instance_sel);
					if (bd != 0) begin
						month = near_rule.month;
						dd = int'(bd) + $urandom_range(0, 4) - 2;
						if (dd < 0)
							dd = 0;
						if (dd > 31)
							dd = 31;
						day = 5'(dd);
					end
				end
				send_date(year, month, day);
			end
		end
		steady_flow = 1'b0;
	endtask

	// sink holds off for a long stretch while dates keep coming, so the
	// pipeline fills and the input side has to stall
	task automatic test_backpressure();
		set_rules(1'b1, 4'd4, 3'd5, 3'd2, 4'd9, 3'd1, INST_LAST);
		steady_flow = 1'b1;
		sink_hold = HOLD_CYCLES;
		for (int i = 0; i < PRESSURE_DATES; i++)
			send_date(14'($urandom_range(1970, 2100)), 4'($urandom_range(1, 12)),
				5'($urandom_range(1, 31)));
		steady_flow = 1'b0;
	endtask

	initial begin : main
		saving_on = 1'b0;
		start_rule = '{month: 4'd3, weekday: 3'd0, instance_sel: 3'd1};
		end_rule = '{month: 4'd11, weekday: 3'd0, instance_sel: 3'd0};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed_dates();
		test_rule_extremes();
		test_invalid_rules();
		test_disabled();
		test_random_dates();
		test_backpressure();

		// let the last words drain, then wait out the pipeline tail for strays
		wait_idle();

		$display("compared %0d result words for %0d dates under %0d rule settings",
			results_checked, dates_sent, rule_sets);
		$display("years 0..16383, raw months and days, unusable rules, %0d-cycle sink hold",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("tb_dst_window_check_top passed");
		end else begin
			$display("tb_dst_window_check_top failed");
		end
		$finish;
	end

endmodule
